/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk with rst_n low masking it
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* design/bda_pkg.sv */
// ----------------------------------------------------------------------------
// bda_pkg
// shared types and constants of the button debounce / autorepeat core
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int ADC_BITS    = 12;
    localparam int OUT_W       = 9;
    localparam int STEP_W      = 5;
    localparam int TIME_W      = 8;
    localparam int HOLD_W      = TIME_W + 1;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 3;

    localparam int NUM_INPUTS_DEF    = 9;
    localparam int DEBOUNCE_FULL_DEF = 16;

    // joystick direction bits sit right above the buttons
    localparam int JOY_RIGHT = NUM_BUTTONS + 0;
    localparam int JOY_LEFT  = NUM_BUTTONS + 1;
    localparam int JOY_UP    = NUM_BUTTONS + 2;
    localparam int JOY_DOWN  = NUM_BUTTONS + 3;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_UP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PRESS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RELEASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PER   = 3'd7;

    localparam logic [STEP_W-1:0]   RST_STEP_UP      = 5'd1;
    localparam logic [STEP_W-1:0]   RST_STEP_DOWN    = 5'd1;
    localparam logic [ADC_BITS-1:0] RST_HIGH_PRESS   = 12'd3595;
    localparam logic [ADC_BITS-1:0] RST_HIGH_RELEASE = 12'd3095;
    localparam logic [ADC_BITS-1:0] RST_LOW_PRESS    = 12'd500;
    localparam logic [ADC_BITS-1:0] RST_LOW_RELEASE  = 12'd1000;
    localparam logic [TIME_W-1:0]   RST_REPEAT_DELAY = 8'd100;
    localparam logic [TIME_W-1:0]   RST_REPEAT_PER   = 8'd30;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_buttons;
        logic [ADC_BITS-1:0]    joystick_x;
        logic [ADC_BITS-1:0]    joystick_y;
    } bda_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] press_events;
        logic [OUT_W-1:0] held_buttons;
    } bda_out_t;

    typedef struct packed {
        logic [STEP_W-1:0]   debounce_step_up;
        logic [STEP_W-1:0]   debounce_step_down;
        logic [ADC_BITS-1:0] high_press_level;
        logic [ADC_BITS-1:0] high_release_level;
        logic [ADC_BITS-1:0] low_press_level;
        logic [ADC_BITS-1:0] low_release_level;
        logic [TIME_W-1:0]   repeat_delay;
        logic [TIME_W-1:0]   repeat_period;
    } bda_cfg_t;

endpackage

`default_nettype wire

/* design/bda_debounce.sv */
// ----------------------------------------------------------------------------
// bda_debounce
// per-button integrators and joystick hysteresis, holds the debounced bits
// ----------------------------------------------------------------------------
`default_nettype none

module bda_debounce #(
    parameter int NUM_INPUTS    = bda_pkg::NUM_INPUTS_DEF,
    parameter int DEBOUNCE_FULL = bda_pkg::DEBOUNCE_FULL_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  bda_pkg::bda_cfg_t     cfg,
    input  bda_pkg::bda_in_t      sample,
    output logic [NUM_INPUTS-1:0] held,
    output logic [NUM_INPUTS-1:0] held_next
);

    localparam int LVL_W  = $clog2(DEBOUNCE_FULL + 1);
    localparam int SUM_W  = ((LVL_W > bda_pkg::STEP_W) ? LVL_W : bda_pkg::STEP_W) + 1;
    localparam int WORK_W = (NUM_INPUTS > bda_pkg::NUM_BUTTONS + 4) ?
                            NUM_INPUTS : bda_pkg::NUM_BUTTONS + 4;

    logic [LVL_W-1:0]      level_reg  [bda_pkg::NUM_BUTTONS];
    logic [LVL_W-1:0]      level_next [bda_pkg::NUM_BUTTONS];
    logic [NUM_INPUTS-1:0] bits_reg;
    logic [WORK_W-1:0]     work;
    logic [SUM_W-1:0]      sum [bda_pkg::NUM_BUTTONS];

    always_comb
    begin
        work = WORK_W'(bits_reg);
        for (int i = 0; i < bda_pkg::NUM_BUTTONS; i++)
        begin
            sum[i] = SUM_W'(level_reg[i]) + SUM_W'(cfg.debounce_step_up);
            if (sample.raw_buttons[i])
            begin
                if (sum[i] >= SUM_W'(DEBOUNCE_FULL))
                begin
                    level_next[i] = LVL_W'(DEBOUNCE_FULL);
                    work[i]       = 1'b1;
                end
                else
                begin
                    level_next[i] = sum[i][LVL_W-1:0];
                end
            end
            else if (SUM_W'(cfg.debounce_step_down) >= SUM_W'(level_reg[i]))
            begin
                level_next[i] = '0;
                work[i]       = 1'b0;
            end
            else
            begin
                level_next[i] = LVL_W'(SUM_W'(level_reg[i]) - SUM_W'(cfg.debounce_step_down));
            end
        end

        // press test first, release test after it: both true clears
        if (sample.joystick_x > cfg.high_press_level)   work[bda_pkg::JOY_RIGHT] = 1'b1;
        if (sample.joystick_x < cfg.high_release_level) work[bda_pkg::JOY_RIGHT] = 1'b0;
        if (sample.joystick_x < cfg.low_press_level)    work[bda_pkg::JOY_LEFT]  = 1'b1;
        if (sample.joystick_x > cfg.low_release_level)  work[bda_pkg::JOY_LEFT]  = 1'b0;
        if (sample.joystick_y > cfg.high_press_level)   work[bda_pkg::JOY_UP]    = 1'b1;
        if (sample.joystick_y < cfg.high_release_level) work[bda_pkg::JOY_UP]    = 1'b0;
        if (sample.joystick_y < cfg.low_press_level)    work[bda_pkg::JOY_DOWN]  = 1'b1;
        if (sample.joystick_y > cfg.low_release_level)  work[bda_pkg::JOY_DOWN]  = 1'b0;
    end

    assign held_next = work[NUM_INPUTS-1:0];
    assign held      = bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            for (int i = 0; i < bda_pkg::NUM_BUTTONS; i++)
            begin
                level_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            bits_reg <= held_next;
            for (int i = 0; i < bda_pkg::NUM_BUTTONS; i++)
            begin
                level_reg[i] <= level_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* design/bda_repeat.sv */
// ----------------------------------------------------------------------------
// bda_repeat
// edge detect and autorepeat hold counters, one per debounced input
// ----------------------------------------------------------------------------
`default_nettype none

module bda_repeat #(
    parameter int NUM_INPUTS = bda_pkg::NUM_INPUTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  bda_pkg::bda_cfg_t     cfg,
    input  logic [NUM_INPUTS-1:0] held,
    input  logic [NUM_INPUTS-1:0] held_next,
    output logic [NUM_INPUTS-1:0] presses
);

    localparam int HW = bda_pkg::HOLD_W;

    logic [HW-1:0] hold_reg  [NUM_INPUTS];
    logic [HW-1:0] hold_next [NUM_INPUTS];
    logic [HW-1:0] inc       [NUM_INPUTS];
    logic [HW-1:0] delay_ext;
    logic [HW-1:0] period_ext;

    assign delay_ext  = HW'(cfg.repeat_delay);
    assign period_ext = HW'(cfg.repeat_period);

    always_comb
    begin
        presses = ~held & held_next;
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            inc[i]       = hold_reg[i] + HW'(1);
            hold_next[i] = '0;
            if (held_next[i])
            begin
                hold_next[i] = inc[i];
                // wrap back to the delay point instead of counting on
                if (inc[i] > delay_ext && (inc[i] - delay_ext) >= period_ext)
                begin
                    hold_next[i] = delay_ext;
                    presses[i]   = 1'b1;
                end
                else if (inc[i] == delay_ext)
                begin
                    presses[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                hold_reg[i] <= hold_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* design/button_debounce_autorepeat_core.sv */
// path: a request is registered in the input register, then its result in the result register
// throughput: one scan tick per cycle; input register and result register
// both keep flowing while the downstream side takes results
// reset: integrators, debounced bits and hold counters clear to zero,
// configuration registers return to their defaults, both stages go empty
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core
// integrating button debouncer, joystick thresholds and autorepeat
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_autorepeat_core #(
    parameter int NUM_INPUTS    = bda_pkg::NUM_INPUTS_DEF,
    parameter int DEBOUNCE_FULL = bda_pkg::DEBOUNCE_FULL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bda_pkg::bda_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bda_pkg::bda_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_W-1:0]       cfg_data
);

    localparam int EXT_W = (NUM_INPUTS > bda_pkg::OUT_W) ? NUM_INPUTS : bda_pkg::OUT_W;

    bda_pkg::bda_cfg_t cfg_reg;
    bda_pkg::bda_in_t  s1_data_reg;
    bda_pkg::bda_out_t out_data_reg;
    bda_pkg::bda_out_t result;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    logic [NUM_INPUTS-1:0] held;
    logic [NUM_INPUTS-1:0] held_next;
    logic [NUM_INPUTS-1:0] presses;
    logic [EXT_W-1:0]      held_ext;
    logic [EXT_W-1:0]      press_ext;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_step_up   <= bda_pkg::RST_STEP_UP;
            cfg_reg.debounce_step_down <= bda_pkg::RST_STEP_DOWN;
            cfg_reg.high_press_level   <= bda_pkg::RST_HIGH_PRESS;
            cfg_reg.high_release_level <= bda_pkg::RST_HIGH_RELEASE;
            cfg_reg.low_press_level    <= bda_pkg::RST_LOW_PRESS;
            cfg_reg.low_release_level  <= bda_pkg::RST_LOW_RELEASE;
            cfg_reg.repeat_delay       <= bda_pkg::RST_REPEAT_DELAY;
            cfg_reg.repeat_period      <= bda_pkg::RST_REPEAT_PER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bda_pkg::REG_STEP_UP:
                    cfg_reg.debounce_step_up   <= cfg_data[bda_pkg::STEP_W-1:0];
                bda_pkg::REG_STEP_DOWN:
                    cfg_reg.debounce_step_down <= cfg_data[bda_pkg::STEP_W-1:0];
                bda_pkg::REG_HIGH_PRESS:
                    cfg_reg.high_press_level   <= cfg_data[bda_pkg::ADC_BITS-1:0];
                bda_pkg::REG_HIGH_RELEASE:
                    cfg_reg.high_release_level <= cfg_data[bda_pkg::ADC_BITS-1:0];
                bda_pkg::REG_LOW_PRESS:
                    cfg_reg.low_press_level    <= cfg_data[bda_pkg::ADC_BITS-1:0];
                bda_pkg::REG_LOW_RELEASE:
                    cfg_reg.low_release_level  <= cfg_data[bda_pkg::ADC_BITS-1:0];
                bda_pkg::REG_REPEAT_DELAY:
                    cfg_reg.repeat_delay       <= cfg_data[bda_pkg::TIME_W-1:0];
                bda_pkg::REG_REPEAT_PER:
                    cfg_reg.repeat_period      <= cfg_data[bda_pkg::TIME_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // stage 1 moves into the result register when that one is free or drains
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    bda_debounce #(
        .NUM_INPUTS    (NUM_INPUTS),
        .DEBOUNCE_FULL (DEBOUNCE_FULL)
    ) u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .sample    (s1_data_reg),
        .held      (held),
        .held_next (held_next)
    );

    bda_repeat #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_repeat (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .held      (held),
        .held_next (held_next),
        .presses   (presses)
    );

    // fit the internal bit vectors to the fixed output width
    assign held_ext            = EXT_W'(held_next);
    assign press_ext           = EXT_W'(presses);
    assign result.held_buttons = held_ext[bda_pkg::OUT_W-1:0];
    assign result.press_events = press_ext[bda_pkg::OUT_W-1:0];

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_press_is_held, out_valid_reg, (out_data_reg.press_events & ~out_data_reg.held_buttons) == '0, "press reported on a bit that is not held")
    `ASSERT_IMPL(a_stall_full, !in_ready, s1_valid_reg && out_valid_reg && !out_ready, "input stalled while pipeline can move")
    `ASSERT_NEXT(a_drain, out_valid_reg && out_ready && !s1_valid_reg, !out_valid_reg, "result register did not empty after last request was taken")

endmodule

`default_nettype wire
